FILE: hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define TPWS_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, off while reset is asserted.
`define TPWS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hdl/tpws_pkg.sv
// Package: widths, codes and types of the timed pin write scheduler.
package tpws_pkg;

    localparam int PIN_W           = 8;
    localparam int VALUE_W         = 16;
    localparam int DELAY_W         = 32;
    localparam int RATE_W          = 14;
    localparam logic [RATE_W-1:0] RATE_RESET = 14'd1000;

    localparam int MAX_BURST       = 32;
    localparam int DEF_QUEUE_DEPTH = 32;
    localparam int DEF_TIME_WIDTH  = 32;

    // Millisecond to tick conversion: (delay * rate) / 1000 as (product >> 3) / 125,
    // by multiplying with ceil(2^50 / 125) and keeping the bits from 50 up.
    localparam int PROD_W      = DELAY_W + RATE_W;
    localparam int DIV_W       = PROD_W - 9;
    localparam int NUM_W       = PROD_W - 3;
    localparam int HALF_W      = 22;
    localparam int PP_W        = 2 * HALF_W;
    localparam int RECIP_W     = 2 * HALF_W;
    localparam int RECIP_SHIFT = 50;
    localparam int ACC_W       = NUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = 44'd9007199254741;

    localparam logic OP_TICK     = 1'b0;
    localparam logic OP_SCHEDULE = 1'b1;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_REJECT = 1'b1;

    typedef struct packed {
        logic [PIN_W-1:0]   pin;
        logic               digital;
        logic [VALUE_W-1:0] value;
    } pay_t;

    typedef struct packed {
        logic insert;
        logic pop;
    } cell_ctrl_t;

endpackage

FILE: hdl/tpws_if.sv
// Interfaces: input and output channels of the timed pin write scheduler.
interface tpws_in_if;
    logic                         valid;
    logic                         ready;
    logic                         op;
    logic                         start_sequence;
    logic [tpws_pkg::PIN_W-1:0]   pin;
    logic                         digital;
    logic [tpws_pkg::VALUE_W-1:0] write_value;
    logic [tpws_pkg::DELAY_W-1:0] delay_ms;

    modport source (
        output valid, op, start_sequence, pin, digital, write_value, delay_ms,
        input  ready
    );
    modport sink (
        input  valid, op, start_sequence, pin, digital, write_value, delay_ms,
        output ready
    );
endinterface

interface tpws_out_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [tpws_pkg::PIN_W-1:0]   out_pin;
    logic                         out_digital;
    logic [tpws_pkg::VALUE_W-1:0] out_value;
    logic                         last;

    modport source (
        output valid, kind, out_pin, out_digital, out_value, last,
        input  ready
    );
    modport sink (
        input  valid, kind, out_pin, out_digital, out_value, last,
        output ready
    );
endinterface

FILE: hdl/tpws_cell.sv
// Queue cell: one slot of the time-sorted chain of pending writes.
module tpws_cell #(
    parameter int TIME_WIDTH = tpws_pkg::DEF_TIME_WIDTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tpws_pkg::cell_ctrl_t  ctrl,
    input  tpws_pkg::pay_t        new_pay,
    input  logic [TIME_WIDTH-1:0] new_run,
    input  logic                  prev_gt,
    input  logic                  prev_valid,
    input  tpws_pkg::pay_t        prev_pay,
    input  logic [TIME_WIDTH-1:0] prev_run,
    input  logic                  next_valid,
    input  tpws_pkg::pay_t        next_pay,
    input  logic [TIME_WIDTH-1:0] next_run,
    output logic                  valid,
    output tpws_pkg::pay_t        pay,
    output logic [TIME_WIDTH-1:0] run,
    output logic                  gt
);
    import tpws_pkg::*;

    logic                  valid_reg, valid_next;
    pay_t                  pay_reg, pay_next;
    logic [TIME_WIDTH-1:0] run_reg, run_next;

    // An empty slot sorts after everything.
    assign gt    = !valid_reg || (run_reg > new_run);
    assign valid = valid_reg;
    assign pay   = pay_reg;
    assign run   = run_reg;

    always_comb
    begin
        valid_next = valid_reg;
        pay_next   = pay_reg;
        run_next   = run_reg;
        if (ctrl.pop)
        begin
            valid_next = next_valid;
            pay_next   = next_pay;
            run_next   = next_run;
        end
        else if (ctrl.insert && gt)
        begin
            // Shift right behind a later neighbor, else take the new write.
            if (prev_gt)
            begin
                valid_next = prev_valid;
                pay_next   = prev_pay;
                run_next   = prev_run;
            end
            else
            begin
                valid_next = 1'b1;
                pay_next   = new_pay;
                run_next   = new_run;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pay_reg <= pay_next;
        run_reg <= run_next;
    end

endmodule

FILE: hdl/tpws_div1000.sv
// Delay converter: registers delay * rate, then divides by 1000 by reciprocal multiplication.
module tpws_div1000 (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [tpws_pkg::DELAY_W-1:0]  delay,
    input  logic [tpws_pkg::RATE_W-1:0]   rate,
    output logic                          done,
    output logic [tpws_pkg::DIV_W-1:0]    quotient
);
    import tpws_pkg::*;

    logic [2:0]          stage_reg;
    logic                done_reg;
    logic [NUM_W-1:0]    num_reg;
    logic [PP_W-1:0]     pp_ll_reg;
    logic [PP_W-1:0]     pp_lh_reg;
    logic [PP_W-1:0]     pp_hl_reg;
    logic [PP_W-1:0]     pp_hh_reg;
    logic [PP_W:0]       mid_reg;
    logic [DIV_W-1:0]    quo_reg;

    logic [PROD_W-1:0]   prod;
    logic [HALF_W-1:0]   num_lo;
    logic [HALF_W-1:0]   num_hi;
    logic [HALF_W-1:0]   recip_lo;
    logic [HALF_W-1:0]   recip_hi;
    logic [ACC_W-1:0]    acc;

    assign prod     = PROD_W'(delay) * PROD_W'(rate);
    assign num_lo   = num_reg[HALF_W-1:0];
    assign num_hi   = HALF_W'(num_reg[NUM_W-1:HALF_W]);
    assign recip_lo = RECIP[HALF_W-1:0];
    assign recip_hi = RECIP[RECIP_W-1:HALF_W];

    // Reassemble the full product from the half-width partial products.
    assign acc = ACC_W'({pp_hh_reg, PP_W'(0)}) + ACC_W'({mid_reg, HALF_W'(0)})
               + ACC_W'(pp_ll_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            stage_reg <= {stage_reg[1:0], start};
            done_reg  <= stage_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= prod[PROD_W-1:3];
        end
        if (stage_reg[0])
        begin
            pp_ll_reg <= PP_W'(num_lo) * PP_W'(recip_lo);
            pp_lh_reg <= PP_W'(num_lo) * PP_W'(recip_hi);
            pp_hl_reg <= PP_W'(num_hi) * PP_W'(recip_lo);
            pp_hh_reg <= PP_W'(num_hi) * PP_W'(recip_hi);
        end
        if (stage_reg[1])
        begin
            mid_reg <= {1'b0, pp_lh_reg} + {1'b0, pp_hl_reg};
        end
        if (stage_reg[2])
        begin
            quo_reg <= acc[ACC_W-1:RECIP_SHIFT];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: hdl/timed_pin_write_scheduler_core.sv
// A tick advances the tick counter, then pops each due write (up to 32) into the output register.
// A schedule transaction passes the multiply step and the 3 reciprocal multiply and sum steps
// of the /1000 converter, then the sequence time update; the chain inserts in the accepting cycle.
// Throughput: one transaction at a time; the converter sets the schedule rate, the chain
// pops one write per cycle while the output slot is free, which sets the drain rate.
// Reset: queue empty, tick counter and sequence time 0, tick rate 1000.
module timed_pin_write_scheduler_core #(
    parameter int QUEUE_DEPTH = tpws_pkg::DEF_QUEUE_DEPTH,
    parameter int TIME_WIDTH  = tpws_pkg::DEF_TIME_WIDTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    tpws_in_if.sink                      in_ch,
    tpws_out_if.source                   out_ch,
    input  logic                         cfg_write,
    input  logic [tpws_pkg::RATE_W-1:0]  cfg_data
);
    import tpws_pkg::*;

    localparam int BURST_W = $clog2(MAX_BURST);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_DIV   = 4'b0010,
        S_REJ   = 4'b0100,
        S_DRAIN = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    logic [TIME_WIDTH-1:0] now_reg;
    logic [TIME_WIDTH-1:0] seq_reg;
    logic [TIME_WIDTH-1:0] run_at_reg;
    logic [RATE_W-1:0]     rate_reg;
    logic                  reject_reg;
    logic [BURST_W-1:0]    burst_reg;

    logic                  out_valid_reg;
    logic                  out_kind_reg;
    pay_t                  out_pay_reg;
    logic                  out_last_reg;

    logic                  cell_valid [QUEUE_DEPTH];
    pay_t                  cell_pay   [QUEUE_DEPTH];
    logic [TIME_WIDTH-1:0] cell_run   [QUEUE_DEPTH];
    logic                  cell_gt    [QUEUE_DEPTH];

    cell_ctrl_t            ctrl;
    pay_t                  new_pay;
    logic [TIME_WIDTH-1:0] run_new;
    logic                  in_accept;
    logic                  is_sched;
    logic                  full;
    logic                  slot_free;
    logic                  head_due;
    logic                  next_due;
    logic                  burst_end;
    logic                  pop_w;
    logic                  load_rej;
    logic                  drain_last;

    logic                  div_done;
    logic [DIV_W-1:0]      dticks;
    logic [TIME_WIDTH:0]   seq_sum;
    logic [TIME_WIDTH-1:0] seq_sat;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_accept   = in_ch.valid && in_ch.ready;
    assign is_sched    = (in_ch.op == OP_SCHEDULE);
    assign run_new     = in_ch.start_sequence ? now_reg : seq_reg;
    assign new_pay     = '{pin: in_ch.pin, digital: in_ch.digital, value: in_ch.write_value};
    assign full        = cell_valid[QUEUE_DEPTH-1];

    assign slot_free   = !out_valid_reg || out_ch.ready;
    assign head_due    = cell_valid[0] && (cell_run[0] <= now_reg);
    assign next_due    = cell_valid[1] && (cell_run[1] <= now_reg);
    assign burst_end   = (burst_reg == BURST_W'(MAX_BURST - 1));
    assign pop_w       = (state_reg == S_DRAIN) && slot_free && head_due;
    assign load_rej    = reject_reg && slot_free;
    assign drain_last  = !next_due || burst_end;

    assign ctrl.insert = in_accept && is_sched && !full;
    assign ctrl.pop    = pop_w;

    // Saturating advance of the sequence time.
    assign seq_sum = {1'b0, run_at_reg} + {1'b0, dticks[TIME_WIDTH-1:0]};
    assign seq_sat = ((|dticks[DIV_W-1:TIME_WIDTH]) || seq_sum[TIME_WIDTH])
                   ? {TIME_WIDTH{1'b1}} : seq_sum[TIME_WIDTH-1:0];

    tpws_div1000 u_conv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_accept && is_sched),
        .delay    (in_ch.delay_ms),
        .rate     (rate_reg),
        .done     (div_done),
        .quotient (dticks)
    );

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic                  prev_gt;
        logic                  prev_valid;
        pay_t                  prev_pay;
        logic [TIME_WIDTH-1:0] prev_run;
        logic                  next_valid;
        pay_t                  next_pay;
        logic [TIME_WIDTH-1:0] next_run;

        if (i == 0)
        begin : g_head
            assign prev_gt    = 1'b0;
            assign prev_valid = 1'b0;
            assign prev_pay   = '0;
            assign prev_run   = '0;
        end
        else
        begin : g_link_prev
            assign prev_gt    = cell_gt[i-1];
            assign prev_valid = cell_valid[i-1];
            assign prev_pay   = cell_pay[i-1];
            assign prev_run   = cell_run[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign next_valid = 1'b0;
            assign next_pay   = '0;
            assign next_run   = '0;
        end
        else
        begin : g_link_next
            assign next_valid = cell_valid[i+1];
            assign next_pay   = cell_pay[i+1];
            assign next_run   = cell_run[i+1];
        end

        tpws_cell #(
            .TIME_WIDTH (TIME_WIDTH)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .new_pay    (new_pay),
            .new_run    (run_new),
            .prev_gt    (prev_gt),
            .prev_valid (prev_valid),
            .prev_pay   (prev_pay),
            .prev_run   (prev_run),
            .next_valid (next_valid),
            .next_pay   (next_pay),
            .next_run   (next_run),
            .valid      (cell_valid[i]),
            .pay        (cell_pay[i]),
            .run        (cell_run[i]),
            .gt         (cell_gt[i])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = is_sched ? S_DIV : S_DRAIN;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = (reject_reg && !slot_free) ? S_REJ : S_IDLE;
                end
            end
            S_REJ:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_DRAIN:
            begin
                if (!head_due || (pop_w && drain_last))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            now_reg       <= '0;
            seq_reg       <= '0;
            rate_reg      <= RATE_RESET;
            reject_reg    <= 1'b0;
            burst_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                rate_reg <= cfg_data;
            end
            if (in_accept && is_sched)
            begin
                reject_reg <= full;
            end
            else if (load_rej)
            begin
                reject_reg <= 1'b0;
            end
            if (in_accept && !is_sched)
            begin
                now_reg   <= now_reg + TIME_WIDTH'(1);
                burst_reg <= '0;
            end
            else if (pop_w)
            begin
                burst_reg <= burst_reg + BURST_W'(1);
            end
            if ((state_reg == S_DIV) && div_done)
            begin
                seq_reg <= seq_sat;
            end
            if (load_rej || pop_w)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && is_sched)
        begin
            run_at_reg <= run_new;
        end
        if (load_rej)
        begin
            out_kind_reg <= KIND_REJECT;
            out_pay_reg  <= '0;
            out_last_reg <= 1'b1;
        end
        else if (pop_w)
        begin
            out_kind_reg <= KIND_WRITE;
            out_pay_reg  <= cell_pay[0];
            out_last_reg <= drain_last;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.kind        = out_kind_reg;
    assign out_ch.out_pin     = out_pay_reg.pin;
    assign out_ch.out_digital = out_pay_reg.digital;
    assign out_ch.out_value   = out_pay_reg.value;
    assign out_ch.last        = out_last_reg;

endmodule

FILE: hdl/tpws_checker.sv
// Checker: port-level assertions for the timed pin write scheduler, bound to the top level.
`include "assert_macros.svh"

module tpws_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         in_op,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic                         out_kind,
    input logic [tpws_pkg::PIN_W-1:0]   out_pin,
    input logic                         out_digital,
    input logic [tpws_pkg::VALUE_W-1:0] out_value,
    input logic                         out_last
);
    import tpws_pkg::*;

    // Hold a stalled result transaction.
    `TPWS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_pin) && $stable(out_digital) && $stable(out_value) && $stable(out_last))

    // A rejection is the only result of its transaction and carries no write.
    `TPWS_ASSERT_NOW(a_reject_form, clk, rst_n, out_valid && (out_kind == KIND_REJECT), out_last && (out_pin == '0) && !out_digital && (out_value == '0))

    // Busy converting the delay right after a schedule transaction.
    `TPWS_ASSERT_NEXT(a_sched_busy, clk, rst_n, in_valid && in_ready && (in_op == OP_SCHEDULE), !in_ready)

    // Busy draining right after a tick transaction.
    `TPWS_ASSERT_NEXT(a_tick_busy, clk, rst_n, in_valid && in_ready && (in_op == OP_TICK), !in_ready)

endmodule

bind timed_pin_write_scheduler_core tpws_checker u_tpws_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_op       (in_ch.op),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_kind    (out_ch.kind),
    .out_pin     (out_ch.out_pin),
    .out_digital (out_ch.out_digital),
    .out_value   (out_ch.out_value),
    .out_last    (out_ch.last)
);
